// ----- hw/rtl/rqme_pkg.sv -----
// Package for the request queue: payload words, command word, status codes
// and sequencer states. Used by every file of the block but rqme_fifo; no dependencies.
package rqme_pkg;

	localparam int QUEUE_DEPTH_DEF   = 16;
	localparam int MAX_RESOURCES_DEF = 4;
	localparam int RES_N             = 4;
	localparam int VAL_W             = 16;
	localparam int QTY_W             = 3;
	localparam int OCC_W             = 5;

	localparam logic [1:0] FN_PUSH    = 2'd0;
	localparam logic [1:0] FN_POP     = 2'd1;
	localparam logic [1:0] FN_EXTRACT = 2'd2;

	typedef enum logic [1:0] {
		OP_PUSH,
		OP_POP,
		OP_EXTRACT,
		OP_NOP
	} op_e;

	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2,
		ST_QTY  = 2'd3
	} status_e;

	typedef enum logic [1:0] {
		B_IDLE,
		B_SCAN,
		B_SHIFT
	} back_e;

	typedef struct packed {
		logic [1:0]       func;
		logic [VAL_W-1:0] train_id;
		logic [VAL_W-1:0] reply_tag;
		logic [QTY_W-1:0] quantity;
		logic [VAL_W-1:0] res_0;
		logic [VAL_W-1:0] res_1;
		logic [VAL_W-1:0] res_2;
		logic [VAL_W-1:0] res_3;
		logic [VAL_W-1:0] key;
	} in_t;

	typedef struct packed {
		status_e          status;
		logic [VAL_W-1:0] out_train_id;
		logic [VAL_W-1:0] out_reply_tag;
		logic [QTY_W-1:0] out_quantity;
		logic [VAL_W-1:0] out_res_0;
		logic [VAL_W-1:0] out_res_1;
		logic [VAL_W-1:0] out_res_2;
		logic [VAL_W-1:0] out_res_3;
		logic [OCC_W-1:0] occupancy;
	} out_t;

	typedef struct packed {
		logic [VAL_W-1:0]            train;
		logic [VAL_W-1:0]            tag;
		logic [QTY_W-1:0]            count;
		logic [RES_N-1:0][VAL_W-1:0] res;
	} ent_t;

	typedef struct packed {
		op_e              op;
		logic             qty_err;
		ent_t             ent;
		logic [VAL_W-1:0] key;
	} cmd_t;

	typedef struct packed {
		logic take;
	} cmd_hs_t;

endpackage

// ----- hw/rtl/rqme_fifo.sv -----
// Two-word queue of W-bit words with push/full and pop/empty sides.
// Used for the command queue and the result queue; no dependencies.
module rqme_fifo #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         rd,
	output logic [W-1:0] rdata,
	output logic         empty
);
	logic [W-1:0] slot_q [2];
	logic         wp_q;
	logic         rp_q;
	logic [1:0]   cnt_q;
	logic         do_wr;
	logic         do_rd;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rdata = slot_q[rp_q];
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
		end else begin
			cnt_q <= cnt_q + {1'b0, do_wr} - {1'b0, do_rd};
			if (do_wr) begin
				wp_q <= !wp_q;
			end
			if (do_rd) begin
				rp_q <= !rp_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wp_q] <= wdata;
		end
	end

endmodule

// ----- hw/rtl/rqme_front.sv -----
// Front end: accepts input words, decodes the operation, checks the count
// and masks unused resources, then queues the command. Uses rqme_pkg, rqme_fifo.
module rqme_front #(
	parameter int MAX_RESOURCES = rqme_pkg::MAX_RESOURCES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  rqme_pkg::in_t       item,
	input  rqme_pkg::cmd_hs_t   hs_in,
	output logic                cmd_vld,
	output rqme_pkg::cmd_t      cmd
);
	import rqme_pkg::*;

	cmd_t                        dec;
	logic                        cq_empty;
	logic [RES_N-1:0][VAL_W-1:0] raw;

	assign raw = {item.res_3, item.res_2, item.res_1, item.res_0};

	always_comb begin
		dec = '0;
		unique case (item.func)
			FN_PUSH:    dec.op = OP_PUSH;
			FN_POP:     dec.op = OP_POP;
			FN_EXTRACT: dec.op = OP_EXTRACT;
			default:    dec.op = OP_NOP;
		endcase
		dec.qty_err   = (32'(item.quantity) > MAX_RESOURCES);
		dec.ent.train = item.train_id;
		dec.ent.tag   = item.reply_tag;
		dec.ent.count = item.quantity;
		for (int i = 0; i < RES_N; i++) begin
			dec.ent.res[i] = (32'(item.quantity) > i) ? raw[i] : '0;
		end
		dec.key = item.key;
	end

	rqme_fifo #(.W($bits(cmd_t))) u_cmdq (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (push),
		.wdata (dec),
		.full  (full),
		.rd    (hs_in.take),
		.rdata (cmd),
		.empty (cq_empty)
	);

	assign cmd_vld = !cq_empty;

endmodule

// ----- hw/rtl/rqme_back.sv -----
// Back end: holds the request memory and fill level, and runs push, pop and
// extract (scan one entry a cycle, then compact). Uses rqme_pkg.
module rqme_back #(
	parameter int QUEUE_DEPTH = rqme_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_vld,
	input  rqme_pkg::cmd_t    cmd,
	output rqme_pkg::cmd_hs_t hs_out,
	input  logic              res_full,
	output logic              res_push,
	output rqme_pkg::out_t    res_data
);
	import rqme_pkg::*;

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	ent_t             mem [QUEUE_DEPTH];
	ent_t             mem_rd_q;
	ent_t             hit_q, hit_d;
	back_e            state_q, state_d;
	logic [CW-1:0]    fill_q, fill_d;
	logic [CW-1:0]    rd_idx_q, rd_idx_d;
	logic [CW-1:0]    chk_idx_q, chk_idx_d;
	logic             chk_vld_q, chk_vld_d;
	logic [CW-1:0]    sh_rd_q, sh_rd_d;
	logic [AW-1:0]    sh_wr_q, sh_wr_d;
	logic             sh_vld_q, sh_vld_d;
	logic             is_pop_q, is_pop_d;
	logic [VAL_W-1:0] key_q, key_d;
	logic             rd_en;
	logic [AW-1:0]    rd_addr;
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	ent_t             wr_data;
	logic             match;

	assign match = chk_vld_q && (is_pop_q ||
		(mem_rd_q.count == QTY_W'(1) && mem_rd_q.res[0] == key_q));

	always_comb begin
		state_d     = state_q;
		fill_d      = fill_q;
		rd_idx_d    = rd_idx_q;
		chk_idx_d   = chk_idx_q;
		chk_vld_d   = chk_vld_q;
		sh_rd_d     = sh_rd_q;
		sh_wr_d     = sh_wr_q;
		sh_vld_d    = sh_vld_q;
		is_pop_d    = is_pop_q;
		key_d       = key_q;
		hit_d       = hit_q;
		hs_out.take = 1'b0;
		rd_en       = 1'b0;
		rd_addr     = '0;
		wr_en       = 1'b0;
		wr_addr     = '0;
		wr_data     = cmd.ent;
		res_push    = 1'b0;
		res_data    = '0;
		res_data.status    = ST_MISS;
		res_data.occupancy = OCC_W'(fill_q);
		unique case (state_q)
			B_IDLE: begin
				if (cmd_vld && !res_full) begin
					hs_out.take = 1'b1;
					unique case (cmd.op)
						OP_PUSH: begin
							res_push = 1'b1;
							if (cmd.qty_err) begin
								res_data.status = ST_QTY;
							end else if (fill_q == CW'(QUEUE_DEPTH)) begin
								res_data.status = ST_FULL;
							end else begin
								wr_en   = 1'b1;
								wr_addr = fill_q[AW-1:0];
								fill_d  = fill_q + CW'(1);
								res_data.status    = ST_DONE;
								res_data.occupancy = OCC_W'(fill_q + CW'(1));
							end
						end
						OP_POP, OP_EXTRACT: begin
							if (fill_q == '0) begin
								res_push = 1'b1;
							end else begin
								state_d   = B_SCAN;
								rd_idx_d  = '0;
								chk_vld_d = 1'b0;
								is_pop_d  = (cmd.op == OP_POP);
								key_d     = cmd.key;
							end
						end
						default: begin
							res_push = 1'b1;
						end
					endcase
				end
			end
			B_SCAN: begin
				if (match) begin
					hit_d    = mem_rd_q;
					sh_rd_d  = chk_idx_q + CW'(1);
					sh_vld_d = 1'b0;
					state_d  = B_SHIFT;
				end else if (chk_vld_q && chk_idx_q == fill_q - CW'(1)) begin
					res_push = 1'b1;
					state_d  = B_IDLE;
				end else if (rd_idx_q < fill_q) begin
					rd_en     = 1'b1;
					rd_addr   = rd_idx_q[AW-1:0];
					chk_vld_d = 1'b1;
					chk_idx_d = rd_idx_q;
					rd_idx_d  = rd_idx_q + CW'(1);
				end else begin
					chk_vld_d = 1'b0;
				end
			end
			B_SHIFT: begin
				if (sh_vld_q) begin
					wr_en   = 1'b1;
					wr_addr = sh_wr_q;
					wr_data = mem_rd_q;
				end
				if (sh_rd_q < fill_q) begin
					rd_en    = 1'b1;
					rd_addr  = sh_rd_q[AW-1:0];
					sh_vld_d = 1'b1;
					sh_wr_d  = sh_rd_q[AW-1:0] - AW'(1);
					sh_rd_d  = sh_rd_q + CW'(1);
				end else begin
					sh_vld_d = 1'b0;
					fill_d   = fill_q - CW'(1);
					state_d  = B_IDLE;
					res_push = 1'b1;
					res_data.status        = ST_DONE;
					res_data.out_train_id  = hit_q.train;
					res_data.out_reply_tag = hit_q.tag;
					res_data.out_quantity  = hit_q.count;
					res_data.out_res_0     = hit_q.res[0];
					res_data.out_res_1     = hit_q.res[1];
					res_data.out_res_2     = hit_q.res[2];
					res_data.out_res_3     = hit_q.res[3];
					res_data.occupancy     = OCC_W'(fill_q - CW'(1));
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			fill_q    <= '0;
			chk_vld_q <= 1'b0;
			sh_vld_q  <= 1'b0;
		end else begin
			state_q   <= state_d;
			fill_q    <= fill_d;
			chk_vld_q <= chk_vld_d;
			sh_vld_q  <= sh_vld_d;
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_q  <= rd_idx_d;
		chk_idx_q <= chk_idx_d;
		sh_rd_q   <= sh_rd_d;
		sh_wr_q   <= sh_wr_d;
		is_pop_q  <= is_pop_d;
		key_q     <= key_d;
		hit_q     <= hit_d;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			mem_rd_q <= mem[rd_addr];
		end
	end

endmodule

// ----- hw/rtl/request_queue_match_extract.sv -----
// Top level of the request queue: front decode, command queue, back-end
// sequencer with request memory, result queue. Uses rqme_pkg, rqme_front,
// rqme_back, rqme_fifo.
//
// Ordered queue of up to QUEUE_DEPTH requests. Each input word is a push,
// a pop of the head or an extract of the oldest request with count one whose
// first resource equals key; every word yields exactly one result word.
// Input words are taken into a two-word command queue, results leave through
// a two-word result queue, so either side may stall. The back end handles one
// command at a time through a request memory with one read and one write port:
// push and the refused or empty cases are answered from the idle state; pop and
// extract scan one entry per cycle and then move each later entry down one place
// per cycle. No clearing pass is needed after reset.
module request_queue_match_extract #(
	parameter int QUEUE_DEPTH   = rqme_pkg::QUEUE_DEPTH_DEF,
	parameter int MAX_RESOURCES = rqme_pkg::MAX_RESOURCES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  rqme_pkg::in_t  item,
	input  logic           pop,
	output logic           empty,
	output rqme_pkg::out_t result
);
	import rqme_pkg::*;

	cmd_t    cmd;
	logic    cmd_vld;
	cmd_hs_t hs;
	logic    res_full;
	logic    res_push;
	out_t    res_data;

	rqme_front #(.MAX_RESOURCES(MAX_RESOURCES)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.hs_in  (hs),
		.cmd_vld(cmd_vld),
		.cmd    (cmd)
	);

	rqme_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd_vld (cmd_vld),
		.cmd     (cmd),
		.hs_out  (hs),
		.res_full(res_full),
		.res_push(res_push),
		.res_data(res_data)
	);

	rqme_fifo #(.W($bits(out_t))) u_resq (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (res_push),
		.wdata (res_data),
		.full  (res_full),
		.rd    (pop),
		.rdata (result),
		.empty (empty)
	);

endmodule

// ----- hw/rtl/rqme_checker.sv -----
// Port-level checks for the request queue, attached to the top level by
// the bind below. Uses rqme_pkg.
module rqme_checker #(
	parameter int QUEUE_DEPTH   = rqme_pkg::QUEUE_DEPTH_DEF,
	parameter int MAX_RESOURCES = rqme_pkg::MAX_RESOURCES_DEF
) (
	input logic           clk,
	input logic           arst_n,
	input logic           push,
	input logic           full,
	input rqme_pkg::in_t  item,
	input logic           pop,
	input logic           empty,
	input rqme_pkg::out_t result
);
	import rqme_pkg::*;

	a_miss_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.status != ST_DONE) |->
		(result.out_train_id == '0 && result.out_reply_tag == '0 &&
		 result.out_quantity == '0 && result.out_res_0 == '0 &&
		 result.out_res_1 == '0 && result.out_res_2 == '0 && result.out_res_3 == '0))
		else $error("refused or missed word carries request fields");

	a_full_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.status == ST_FULL) |->
		(result.occupancy == OCC_W'(QUEUE_DEPTH)))
		else $error("queue full reported below depth");

	a_quantity_range: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.status == ST_DONE) |->
		(32'(result.out_quantity) <= MAX_RESOURCES))
		else $error("returned request count above limit");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("stalled result word changed");

endmodule

bind request_queue_match_extract rqme_checker #(
	.QUEUE_DEPTH  (QUEUE_DEPTH),
	.MAX_RESOURCES(MAX_RESOURCES)
) u_rqme_checker (.*);

// ----- tb/sv/rqme_tb_pkg.sv -----
`timescale 1ns / 1ps
// Scoreboard for the request queue testbench. It keeps a shadow copy of the held
// requests, predicts one result word per accepted input word and checks the results in order.
// Depends on rqme_pkg.
package rqme_tb_pkg;
	import rqme_pkg::*;

	class queue_shadow;
		ent_t held[QUEUE_DEPTH_DEF];
		int   fill;
		out_t expected_words[$];
		int   fails;

		function new();
			fill = 0;
			fails = 0;
		endfunction

		// remove one request and close the gap behind it
		function out_t take_entry(int idx);
			out_t r;
			r = '0;
			r.status = ST_DONE;
			r.out_train_id = held[idx].train;
			r.out_reply_tag = held[idx].tag;
			r.out_quantity = held[idx].count;
			r.out_res_0 = held[idx].res[0];
			r.out_res_1 = held[idx].res[1];
			r.out_res_2 = held[idx].res[2];
			r.out_res_3 = held[idx].res[3];
			for (int i = idx; i + 1 < fill; i++)
				held[i] = held[i + 1];
			fill--;
			return r;
		endfunction

		function void note_word(in_t w);
			out_t r;
			logic [VAL_W-1:0] carried[RES_N];
			int hit;
			r = '0;
			r.status = ST_MISS;
			hit = -1;
			carried[0] = w.res_0;
			carried[1] = w.res_1;
			carried[2] = w.res_2;
			carried[3] = w.res_3;
			case (w.func)
				FN_PUSH: begin
					if (w.quantity > MAX_RESOURCES_DEF) begin
						r.status = ST_QTY;
					end else if (fill >= QUEUE_DEPTH_DEF) begin
						r.status = ST_FULL;
					end else begin
						held[fill].train = w.train_id;
						held[fill].tag = w.reply_tag;
						held[fill].count = w.quantity;
						for (int i = 0; i < RES_N; i++)
							held[fill].res[i] = (i < w.quantity) ? carried[i] : '0;
						fill++;
						r.status = ST_DONE;
					end
				end
				FN_POP: begin
					if (fill > 0)
						r = take_entry(0);
				end
				FN_EXTRACT: begin
					for (int i = 0; i < fill && hit < 0; i++)
						if (held[i].count == 1 && held[i].res[0] == w.key)
							hit = i;
					if (hit >= 0)
						r = take_entry(hit);
				end
				default: ;
			endcase
			r.occupancy = OCC_W'(fill);
			expected_words.push_back(r);
		endfunction

		function void check_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s expected %0h actual %0h", name, want, got);
				fails++;
			end
		endfunction

		function void check_word(out_t got);
			out_t want;
			if (expected_words.size() == 0) begin
				$error("result word with nothing outstanding: %h", got);
				fails++;
				return;
			end
			want = expected_words.pop_front();
			check_field("status", want.status, got.status);
			check_field("out_train_id", want.out_train_id, got.out_train_id);
			check_field("out_reply_tag", want.out_reply_tag, got.out_reply_tag);
			check_field("out_quantity", want.out_quantity, got.out_quantity);
			check_field("out_res_0", want.out_res_0, got.out_res_0);
			check_field("out_res_1", want.out_res_1, got.out_res_1);
			check_field("out_res_2", want.out_res_2, got.out_res_2);
			check_field("out_res_3", want.out_res_3, got.out_res_3);
			check_field("occupancy", want.occupancy, got.occupancy);
		endfunction
	endclass

endpackage

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// Top of the request queue testbench: clock, reset, push and pop drivers and the
// directed and random word sequences. Depends on rqme_pkg, rqme_tb_pkg and
// request_queue_match_extract.
module tb_top;
	import rqme_pkg::*;
	import rqme_tb_pkg::*;

	localparam int RUN_WORDS   = 800;
	localparam int CYCLE_LIMIT = 500000;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	logic pop;
	logic empty;
	in_t  item;
	out_t result;

	queue_shadow shadow = new();
	int cycles = 0;
	bit calm_in = 1'b0;
	bit calm_out = 1'b0;
	int lean_pct[3] = '{85, 20, 50};

	request_queue_match_extract dut (
		.clk,
		.arst_n,
		.push,
		.full,
		.item,
		.pop,
		.empty,
		.result
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	function automatic logic [VAL_W-1:0] pick_res();
		return ($urandom_range(0, 9) < 6) ? VAL_W'($urandom_range(0, 7)) : VAL_W'($urandom);
	endfunction

	function automatic in_t word_of(logic [1:0] f, logic [VAL_W-1:0] tr, logic [VAL_W-1:0] tg,
			logic [QTY_W-1:0] q, logic [VAL_W-1:0] r0, logic [VAL_W-1:0] r1,
			logic [VAL_W-1:0] r2, logic [VAL_W-1:0] r3, logic [VAL_W-1:0] k);
		in_t w;
		w.func = f;
		w.train_id = tr;
		w.reply_tag = tg;
		w.quantity = q;
		w.res_0 = r0;
		w.res_1 = r1;
		w.res_2 = r2;
		w.res_3 = r3;
		w.key = k;
		return w;
	endfunction

	function automatic in_t random_word(int push_pct);
		in_t w;
		int roll;
		w.train_id = VAL_W'($urandom);
		w.reply_tag = VAL_W'($urandom);
		w.quantity = ($urandom_range(0, 9) < 4) ? QTY_W'(1) : QTY_W'($urandom_range(0, 7));
		w.res_0 = pick_res();
		w.res_1 = VAL_W'($urandom);
		w.res_2 = VAL_W'($urandom);
		w.res_3 = VAL_W'($urandom);
		w.key = pick_res();
		roll = $urandom_range(0, 99);
		if (roll < push_pct)
			w.func = FN_PUSH;
		else if (roll >= 97)
			w.func = OP_NOP;
		else if ($urandom_range(0, 9) < 4)
			w.func = FN_POP;
		else
			w.func = FN_EXTRACT;
		return w;
	endfunction

	task automatic send_word(in_t w);
		int gap;
		if ($urandom_range(0, 31) == 0)
			calm_in = !calm_in;
		gap = calm_in ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push <= 1'b1;
		item <= w;
		do @(posedge clk); while (full);
		shadow.note_word(w);
		@(negedge clk);
	endtask

	task automatic hold_until_drained();
		push <= 1'b0;
		@(negedge clk);
		while (shadow.expected_words.size() != 0)
			@(negedge clk);
	endtask

	initial begin : drain
		int gap;
		pop = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 31) == 0)
				calm_out = !calm_out;
			gap = calm_out ? 0 : $urandom_range(0, 15);
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			shadow.check_word(result);
			@(negedge clk);
		end
	end

	initial begin : stimulus
		int lean;
		arst_n = 1'b0;
		push = 1'b0;
		item = '0;
		lean = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_word(word_of(FN_POP, 16'hFFFF, 16'hFFFF, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 16'hFFFF));
		send_word(word_of(FN_EXTRACT, 16'h0, 16'h0, 3'd0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0));
		send_word(word_of(OP_NOP, 16'hFFFF, 16'hFFFF, 3'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 16'hFFFF));
		send_word(word_of(FN_PUSH, 16'hFFFF, 16'hFFFF, 3'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 16'h0));
		send_word(word_of(FN_PUSH, 16'h0001, 16'h0002, 3'd1, 16'h1234, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 16'h0));
		send_word(word_of(FN_PUSH, 16'h0000, 16'hFFFF, 3'd4, 16'h0001, 16'h8000, 16'h7FFF,
			16'hFFFF, 16'h0));
		send_word(word_of(FN_PUSH, 16'h0005, 16'h0005, 3'd5, 16'h1234, 16'h1, 16'h2, 16'h3,
			16'h0));
		send_word(word_of(FN_PUSH, 16'h0007, 16'h0007, 3'd7, 16'h1234, 16'h1, 16'h2, 16'h3,
			16'h0));
		send_word(word_of(FN_PUSH, 16'hA5A5, 16'h5A5A, 3'd2, 16'h1234, 16'h5678, 16'hFFFF,
			16'hFFFF, 16'h0));
		send_word(word_of(FN_PUSH, 16'h8000, 16'h7FFF, 3'd3, 16'hABCD, 16'h0000, 16'hFFFF,
			16'hFFFF, 16'h0));
		send_word(word_of(FN_PUSH, 16'h0000, 16'h0000, 3'd1, 16'h0000, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 16'h0));
		send_word(word_of(FN_EXTRACT, 16'h0, 16'h0, 3'd0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h1234));
		send_word(word_of(FN_EXTRACT, 16'h0, 16'h0, 3'd0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h1234));
		send_word(word_of(FN_EXTRACT, 16'h0, 16'h0, 3'd0, 16'h0, 16'h0, 16'h0, 16'h0, 16'hFFFF));
		send_word(word_of(FN_EXTRACT, 16'h0, 16'h0, 3'd0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0000));
		repeat (5)
			send_word(word_of(FN_POP, 16'h0, 16'h0, 3'd0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0));
		send_word(word_of(FN_EXTRACT, 16'h0, 16'h0, 3'd1, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0));
		hold_until_drained();

		// open with a push burst so the queue reaches full early
		for (int n = 0; n < RUN_WORDS; n++) begin
			if (n % 24 == 0)
				lean = $urandom_range(0, 2);
			if (n == RUN_WORDS / 2)
				hold_until_drained();
			send_word(random_word(n < 30 ? 100 : lean_pct[lean]));
		end

		hold_until_drained();
		repeat (40) @(negedge clk);
		if (shadow.fails == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
